/* rtl/core/sma_pkg.sv */
// Shared types and constants for the Sobel magnitude/angle core.
package sma_pkg;

   localparam int PIX_W      = 10;   // summed channel value
   localparam int CHAN_W     = 8;
   localparam int KERNEL     = 3;
   localparam int GRAD_W     = 13;   // signed gx / gy
   localparam int ABS_W      = 12;   // |gx|, |gy|
   localparam int SQ_W       = 25;   // gx^2 + gy^2
   localparam int ROOT_W     = 26;   // square root working register
   localparam int MAG_W      = 13;
   localparam int ANG_W      = 15;
   localparam int ANG_SHIFT  = 20;   // Q32 -> Q3.12
   localparam int DEN_W      = 13;
   localparam int QUO_W      = 32;
   localparam int ACC_W      = 36;
   localparam int CNT_W      = 5;
   localparam int SQRT_STEPS = 13;
   localparam int DIV_STEPS  = 32;
   localparam int SERIES_TERMS = 20;
   localparam int HEIGHT_W   = 13;
   localparam int Y_W        = 12;
   localparam int MAX_HEIGHT = 4096;
   localparam int CFG_W      = 13;
   localparam int CFG_WIDTH_W = 11;
   localparam int CFG_COUNT_W = 2;
   localparam int CSR_ADDR_W = 2;

   localparam logic signed [ACC_W-1:0] PI4_Q32 = 36'sd3373259426;
   localparam logic signed [ACC_W-1:0] PI2_Q32 = 36'sd6746518852;
   localparam logic signed [ACC_W-1:0] PI_Q32  = 36'sd13493037705;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 36'sd524288;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam logic ACT_DRAIN = 1'b1;

   typedef struct packed {
      logic             capture;
      logic             update;
      logic             grad;
      logic             sq;
      logic             sqrt_step;
      logic [CNT_W-1:0] idx;
      logic             aprep;
      logic             div_step;
      logic             tmul;
      logic             t2;
      logic             tstart;
      logic             tacc;
      logic             fin1;
      logic             fin2;
      logic             fin3;
      logic             out_load;
      logic [CNT_W-1:0] term;
   } sma_cmd_type;

   typedef struct packed {
      logic has_result;
      logic zero_grad;
   } sma_status_type;

endpackage

/* rtl/core/sma_datapath.sv */
// Datapath: line stores, window, stream counters, root and arctangent units.
module sma_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sma_pkg::sma_cmd_type              cmd,
   output sma_pkg::sma_status_type           status,
   input  logic                              req_action,
   input  logic [sma_pkg::CHAN_W-1:0]        req_chan_a,
   input  logic [sma_pkg::CHAN_W-1:0]        req_chan_b,
   input  logic [sma_pkg::CHAN_W-1:0]        req_chan_c,
   input  logic                              csr_wr_en,
   input  logic [sma_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sma_pkg::CFG_W-1:0]         csr_wdata,
   output logic [sma_pkg::MAG_W-1:0]         rsp_magnitude,
   output logic signed [sma_pkg::ANG_W-1:0]  rsp_angle,
   output logic                              rsp_frame_end
);
   import sma_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int FW = WW + 1;

   // configuration
   logic [CFG_WIDTH_W-1:0] fw_ff;
   logic [HEIGHT_W-1:0]    fh_ff;
   logic [CFG_COUNT_W-1:0] cc_ff;
   logic                   cfg_hit;

   assign cfg_hit = csr_wr_en && (csr_addr == CSR_FRAME_WIDTH ||
                    csr_addr == CSR_FRAME_HEIGHT || csr_addr == CSR_CHANNEL_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= CFG_WIDTH_W'(640);
         fh_ff <= HEIGHT_W'(480);
         cc_ff <= CFG_COUNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:   fw_ff <= csr_wdata[CFG_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:  fh_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_CHANNEL_COUNT: cc_ff <= csr_wdata[CFG_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WW-1:0]       w_eff, w_last;
   logic [HEIGHT_W-1:0] h_eff, h_last;

   always_comb begin
      if (fw_ff == '0)                w_eff = WW'(1);
      else if (32'(fw_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else                            w_eff = WW'(fw_ff);
      if (fh_ff == '0)                 h_eff = HEIGHT_W'(1);
      else if (32'(fh_ff) > MAX_HEIGHT) h_eff = HEIGHT_W'(MAX_HEIGHT);
      else                             h_eff = fh_ff;
   end
   assign w_last = w_eff - WW'(1);
   assign h_last = h_eff - HEIGHT_W'(1);

   // input capture
   logic [PIX_W-1:0] pix_in, pix_ff;

   always_comb begin
      pix_in = '0;
      if (req_action != ACT_DRAIN) begin
         pix_in = PIX_W'(req_chan_a);
         if (cc_ff >= CFG_COUNT_W'(2)) pix_in = pix_in + PIX_W'(req_chan_b);
         if (cc_ff == CFG_COUNT_W'(3)) pix_in = pix_in + PIX_W'(req_chan_c);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) pix_ff <= pix_in;
   end

   // stream counters
   logic [AW-1:0]  ptr_ff, x_ff, xc_ff;
   logic [FW-1:0]  fill_ff;
   logic [Y_W-1:0] y_ff, yc_ff;
   logic           fe_ff;
   logic           has_result, ptr_wrap, x_last, y_last, frame_done;

   assign has_result = fill_ff >= (FW'(w_eff) + FW'(1));
   assign ptr_wrap   = WW'(ptr_ff) == w_last;
   assign x_last     = WW'(x_ff) == w_last;
   assign y_last     = HEIGHT_W'(y_ff) == h_last;
   assign frame_done = has_result && x_last && y_last;

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         ptr_ff  <= '0;
         fill_ff <= '0;
         x_ff    <= '0;
         y_ff    <= '0;
         xc_ff   <= '0;
         yc_ff   <= '0;
         fe_ff   <= 1'b0;
      end else if (cmd.update) begin
         if (frame_done || ptr_wrap) ptr_ff <= '0;
         else                        ptr_ff <= ptr_ff + AW'(1);
         if (!has_result) fill_ff <= fill_ff + FW'(1);
         if (has_result) begin
            xc_ff <= x_ff;
            yc_ff <= y_ff;
            fe_ff <= frame_done;
            if (frame_done) begin
               fill_ff <= '0;
               x_ff    <= '0;
               y_ff    <= '0;
            end else if (x_last) begin
               x_ff <= '0;
               y_ff <= y_ff + Y_W'(1);
            end else begin
               x_ff <= x_ff + AW'(1);
            end
         end
      end
   end

   assign status.has_result = has_result;

   // line stores: row0 holds the previous row, row1 the one before it
   logic [PIX_W-1:0] row0_mem [MAX_WIDTH];
   logic [PIX_W-1:0] row1_mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd0_ff, rd1_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) rd0_ff <= row0_mem[ptr_ff];
      if (cmd.update)  row0_mem[ptr_ff] <= pix_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) rd1_ff <= row1_mem[ptr_ff];
      if (cmd.update)  row1_mem[ptr_ff] <= rd0_ff;
   end

   // 3x3 window, [row][column], newest column on the right
   logic [PIX_W-1:0] win_ff [KERNEL][KERNEL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KERNEL; r++)
            for (int c = 0; c < KERNEL; c++) win_ff[r][c] <= '0;
      end else if (cmd.update) begin
         for (int r = 0; r < KERNEL; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd1_ff;
         win_ff[1][2] <= rd0_ff;
         win_ff[2][2] <= pix_ff;
      end
   end

   // gradients with replicated borders, col[c][r]
   logic signed [GRAD_W-1:0] col [KERNEL][KERNEL];
   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;

   always_comb begin
      for (int c = 0; c < KERNEL; c++)
         for (int r = 0; r < KERNEL; r++) col[c][r] = GRAD_W'(win_ff[r][c]);
      for (int c = 0; c < KERNEL; c++) begin
         if (yc_ff == '0) col[c][0] = col[c][1];
         if (HEIGHT_W'(yc_ff) == h_last) col[c][2] = col[c][1];
      end
      for (int r = 0; r < KERNEL; r++) begin
         if (xc_ff == '0) col[0][r] = col[1][r];
         if (WW'(xc_ff) == w_last) col[2][r] = col[1][r];
      end
      gx_in = (col[2][0] + (col[2][1] <<< 1) + col[2][2])
            - (col[0][0] + (col[0][1] <<< 1) + col[0][2]);
      gy_in = (col[0][2] + (col[1][2] <<< 1) + col[2][2])
            - (col[0][0] + (col[1][0] <<< 1) + col[2][0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   // magnitude: two bits of radicand per step
   logic signed [ROOT_W-1:0] gx2, gy2;
   logic [SQ_W-1:0]          sq_in, sv_ff;
   logic [ROOT_W-1:0]        sres_ff, sbit, strial;

   assign gx2    = ROOT_W'(gx_ff) * ROOT_W'(gx_ff);
   assign gy2    = ROOT_W'(gy_ff) * ROOT_W'(gy_ff);
   assign sq_in  = SQ_W'(gx2 + gy2);
   assign sbit   = ROOT_W'(1) << {cmd.idx, 1'b0};
   assign strial = sres_ff + sbit;

   always_ff @(posedge clock) begin
      if (cmd.sq) begin
         sv_ff   <= sq_in;
         sres_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (ROOT_W'(sv_ff) >= strial) begin
            sv_ff   <= sv_ff - SQ_W'(strial);
            sres_ff <= (sres_ff >> 1) + sbit;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
      end
   end

   // angle: octant reduction
   logic [ABS_W-1:0] ax, ay, mx, mn;
   logic             small_ratio;

   assign ax = ABS_W'(gx_ff[GRAD_W-1] ? -gx_ff : gx_ff);
   assign ay = ABS_W'(gy_ff[GRAD_W-1] ? -gy_ff : gy_ff);
   assign mx = (ax > ay) ? ax : ay;
   assign mn = (ax > ay) ? ay : ax;
   assign small_ratio = {mn, 1'b0} <= {1'b0, mx};
   assign status.zero_grad = (mx == '0);

   logic zero_ff, use_sub_ff, ay_gt_ff;

   always_ff @(posedge clock) begin
      if (cmd.aprep) begin
         zero_ff    <= (mx == '0);
         use_sub_ff <= !small_ratio;
         ay_gt_ff   <= ay > ax;
      end
   end

   // shared radix-2 divider, quotient shifts in as the numerator shifts out
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [QUO_W-1:0] quo_ff, p_ff, t2_ff;
   logic [DEN_W:0]   dtrial, ddiff;
   logic             dge;

   assign dtrial = {rem_ff, quo_ff[QUO_W-1]};
   assign ddiff  = dtrial - {1'b0, den_ff};
   assign dge    = dtrial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.aprep) begin
         rem_ff <= small_ratio ? DEN_W'(mn) : DEN_W'(mx - mn);
         den_ff <= small_ratio ? DEN_W'(mx) : DEN_W'(mx) + DEN_W'(mn);
         quo_ff <= '0;
      end else if (cmd.tstart) begin
         rem_ff <= '0;
         den_ff <= DEN_W'({cmd.term, 1'b1});
         quo_ff <= p_ff;
      end else if (cmd.div_step) begin
         rem_ff <= dge ? DEN_W'(ddiff) : DEN_W'(dtrial);
         quo_ff <= {quo_ff[QUO_W-2:0], dge};
      end
   end

   // shared multiplier: t*t, then p*t2 per series term
   logic [2*QUO_W-1:0] mul_ff;
   logic [QUO_W-1:0]   mul_a, mul_b;

   assign mul_a = cmd.tmul ? quo_ff : p_ff;
   assign mul_b = cmd.tmul ? quo_ff : t2_ff;

   always_ff @(posedge clock) begin
      if (cmd.tmul || cmd.tstart) mul_ff <= (2*QUO_W)'(mul_a) * (2*QUO_W)'(mul_b);
   end

   // series accumulation and final angle
   logic signed [ACC_W-1:0] sum_ff, a_ff, base, a2, rounded;
   logic [ANG_W-2:0]        q;
   logic signed [ANG_W-1:0] ang_ff;

   assign base    = use_sub_ff ? PI4_Q32 - sum_ff : sum_ff;
   assign a2      = gx_ff[GRAD_W-1] ? PI_Q32 - a_ff : a_ff;
   assign rounded = a_ff + ROUND_HALF;
   assign q       = rounded[ANG_SHIFT+ANG_W-2:ANG_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.tmul) p_ff <= quo_ff;
      else if (cmd.tacc) p_ff <= mul_ff[2*QUO_W-1:QUO_W];
      if (cmd.t2) begin
         t2_ff  <= mul_ff[2*QUO_W-1:QUO_W];
         sum_ff <= '0;
      end else if (cmd.tacc) begin
         sum_ff <= cmd.term[0] ? sum_ff - ACC_W'(quo_ff) : sum_ff + ACC_W'(quo_ff);
      end
      if (cmd.fin1) a_ff <= ay_gt_ff ? PI2_Q32 - base : base;
      else if (cmd.fin2) a_ff <= (a2 < 0) ? '0 : a2;
      if (cmd.fin3) begin
         if (zero_ff)               ang_ff <= '0;
         else if (gy_ff[GRAD_W-1])  ang_ff <= -ANG_W'(q);
         else                       ang_ff <= ANG_W'(q);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_magnitude <= MAG_W'(sres_ff);
         rsp_angle     <= ang_ff;
         rsp_frame_end <= fe_ff;
      end
   end

endmodule

/* rtl/core/sma_ctrl.sv */
// Controller: sequences capture, update, root, divider and series steps.
module sma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  sma_pkg::sma_status_type status,
   output sma_pkg::sma_cmd_type    cmd
);
   import sma_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_UPDATE = 16'h0002,
      S_GRAD   = 16'h0004,
      S_SQ     = 16'h0008,
      S_SQRT   = 16'h0010,
      S_APREP  = 16'h0020,
      S_DIV    = 16'h0040,
      S_TMUL   = 16'h0080,
      S_T2     = 16'h0100,
      S_TSTART = 16'h0200,
      S_TDIV   = 16'h0400,
      S_TACC   = 16'h0800,
      S_FIN1   = 16'h1000,
      S_FIN2   = 16'h2000,
      S_FIN3   = 16'h4000,
      S_OUT    = 16'h8000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic             rsp_valid_ff, out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.idx  = cnt_ff;
      cmd.term = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.has_result ? S_GRAD : S_IDLE;
         end
         S_GRAD: begin
            cmd.grad = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            cnt_in   = CNT_W'(SQRT_STEPS - 1);
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_APREP;
         end
         S_APREP: begin
            cmd.aprep = 1'b1;
            cnt_in    = CNT_W'(DIV_STEPS - 1);
            state_in  = status.zero_grad ? S_FIN3 : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_TMUL;
         end
         S_TMUL: begin
            cmd.tmul = 1'b1;
            k_in     = '0;
            state_in = S_T2;
         end
         S_T2: begin
            cmd.t2   = 1'b1;
            state_in = S_TSTART;
         end
         S_TSTART: begin
            cmd.tstart = 1'b1;
            cnt_in     = CNT_W'(DIV_STEPS - 1);
            state_in   = S_TDIV;
         end
         S_TDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_TACC;
         end
         S_TACC: begin
            cmd.tacc = 1'b1;
            k_in     = k_ff + CNT_W'(1);
            state_in = (k_ff == CNT_W'(SERIES_TERMS - 1)) ? S_FIN1 : S_TSTART;
         end
         S_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = S_FIN3;
         end
         S_FIN3: begin
            cmd.fin3 = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         if (cmd.out_load)     rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)  rsp_valid_ff <= 1'b0;
      end
   end

endmodule

/* rtl/core/sobel_magnitude_angle_core.sv */
// Top level of the streaming 3x3 Sobel magnitude and angle core.
//
// Pixels arrive in raster order on the req_ channel (valid/stall); each
// transaction is a pixel (req_action 0) or a drain item (1) that pushes a
// zero. After width+1 items every further item yields one rsp_ transaction
// with floor(sqrt(gx^2+gy^2)), atan2(gy,gx) in Q3.12 radians and a frame-end
// flag; width+1 drain items after a frame flush its tail.
// One item is in work at a time; one that yields no result is only captured
// and stored. A result takes a 13-step root; with zero gradient the angle is
// 0 and the divider is skipped, else 21 divisions of 32 steps each run on
// one shared radix-2 divider (the ratio, then the 20 arctangent series terms).
// The result sits in an output register, so the next item is taken while
// rsp_ is stalled; a second finished result waits until the first leaves.
// Configuration is written through csr_, by the user only while idle (not
// enforced by the core); any write of a defined register restarts the frame.
// Reset loads width 640, height 480, one channel, clears window and counters.
// Line store contents are undefined until written and need no clearing pass.
module sobel_magnitude_angle_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [sma_pkg::CHAN_W-1:0]        req_chan_a,
   input  logic [sma_pkg::CHAN_W-1:0]        req_chan_b,
   input  logic [sma_pkg::CHAN_W-1:0]        req_chan_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sma_pkg::MAG_W-1:0]         rsp_magnitude,
   output logic signed [sma_pkg::ANG_W-1:0]  rsp_angle,
   output logic                              rsp_frame_end,
   input  logic                              csr_wr_en,
   input  logic [sma_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sma_pkg::CFG_W-1:0]         csr_wdata
);
   import sma_pkg::*;

   sma_cmd_type    cmd;
   sma_status_type status;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sma_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_action    (req_action),
      .req_chan_a    (req_chan_a),
      .req_chan_b    (req_chan_b),
      .req_chan_c    (req_chan_c),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle     (rsp_angle),
      .rsp_frame_end (rsp_frame_end)
   );

   // an accepted transaction always starts a capture
   a_accept_capture: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> cmd.capture)
      else $error("accepted transaction without capture");

   // capture is always followed by the store/window update
   a_capture_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.update)
      else $error("capture not followed by update");

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten");

   // datapath strobes are mutually exclusive
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.update, cmd.sqrt_step, cmd.div_step, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule
